// ===== rtl/core/kummer_carry_sieve_element_unit_assert.svh =====
// Assertion macros for the Kummer carry sieve element unit
`ifndef KUMMER_CARRY_SIEVE_ELEMENT_UNIT_ASSERT_SVH
`define KUMMER_CARRY_SIEVE_ELEMENT_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define KCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcs assertion failed");

// Next-cycle implication
`define KCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcs assertion failed");

`endif

// ===== rtl/core/kcs_pkg.sv =====
// Package: shared types and constants of the Kummer carry sieve element unit
package kcs_pkg;
  localparam int unsigned VW = 64;
  localparam int unsigned PW = 32;
  localparam int unsigned KW = 16;
  localparam int unsigned CW = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_NU, ST_DIG, ST_REM1, ST_STRIP, ST_OUT
  } state_e;

  // Divider operand selects; SRC_Q feeds the quotient just produced
  typedef enum logic [1:0] {
    SRC_C, SRC_T, SRC_REM, SRC_Q
  } src_e;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    logic   div_start;
    src_e   div_src;
    logic   take_q;
    logic   nu_inc;
    logic   dig_step;
    logic   set_out_pass;
    logic   set_out_kill;
    logic   set_out_t;
    logic   set_out_q;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic vin;
    logic p_ok;
    logic test_on;
    logic c_small;
    logic c_lt_p;
    logic div_done;
    logic rem_zero;
    logic t_zero;
    logic q_zero;
    logic over;
  } sts_t;
endpackage

// ===== rtl/core/kcs_if.sv =====
// Interfaces: input and result channels
interface kcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [kcs_pkg::PW-1:0]     prime;
  logic [kcs_pkg::VW-1:0]     multiple_index;
  logic [kcs_pkg::VW-1:0]     remainder;
  logic                       in_valid;
  modport source (output valid, prime, multiple_index, remainder, in_valid, input ready);
  modport sink (input valid, prime, multiple_index, remainder, in_valid, output ready);
endinterface

interface kcs_out_if;
  logic                   valid;
  logic                   ready;
  logic                   out_valid;
  logic [kcs_pkg::VW-1:0] out_remainder;
  modport source (output valid, out_valid, out_remainder, input ready);
  modport sink (input valid, out_valid, out_remainder, output ready);
endinterface

// ===== rtl/core/kcs_divider.sv =====
// Restoring radix-2 divider: 64-bit dividend by 32-bit divisor, one bit per cycle
module kcs_divider (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [kcs_pkg::VW-1:0] dividend_i,
  input  logic [kcs_pkg::PW-1:0] divisor_i,
  output logic                   done_o,
  output logic [kcs_pkg::VW-1:0] quot_o,
  output logic [kcs_pkg::PW-1:0] rem_o
);
  logic [kcs_pkg::CW-1:0]  cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic [kcs_pkg::VW-1:0]  quot_q, quot_d;
  logic [kcs_pkg::PW:0]    rem_q, rem_d;
  logic [kcs_pkg::PW:0]    trial;
  logic [kcs_pkg::PW:0]    shifted;

  // One quotient bit per step
  always_comb begin
    shifted = {rem_q[kcs_pkg::PW-1:0], quot_q[kcs_pkg::VW-1]};
    trial   = shifted - {1'b0, divisor_i};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!trial[kcs_pkg::PW]) begin
        rem_d  = trial;
        quot_d = {quot_q[kcs_pkg::VW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[kcs_pkg::VW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == kcs_pkg::CW'(kcs_pkg::VW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[kcs_pkg::PW-1:0];
endmodule

// ===== rtl/core/kcs_datapath.sv =====
// Datapath: operand registers, shared divider, valuation and carry counters
module kcs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kcs_pkg::cmd_t          cmd_i,
  output kcs_pkg::sts_t          sts_o,
  input  logic [kcs_pkg::KW-1:0] k_i,
  input  logic [kcs_pkg::PW-1:0] prime_i,
  input  logic [kcs_pkg::VW-1:0] c_i,
  input  logic [kcs_pkg::VW-1:0] rem_i,
  input  logic                   vin_i,
  output logic                   out_valid_o,
  output logic [kcs_pkg::VW-1:0] out_rem_o
);
  logic [kcs_pkg::PW-1:0] p_q;
  logic [kcs_pkg::VW-1:0] c_q, rem_q, t_q, orem_q, dvd;
  logic                   vin_q, ov_q, carry_q;
  logic [kcs_pkg::CW-1:0] nu_q, car_q;
  logic                   done;
  logic [kcs_pkg::VW-1:0] quot;
  logic [kcs_pkg::PW-1:0] drem;
  logic [kcs_pkg::PW:0]   d2;
  logic                   dig_cy;

  // Dividend select
  always_comb begin
    case (cmd_i.div_src)
      kcs_pkg::SRC_C:   dvd = c_q;
      kcs_pkg::SRC_REM: dvd = rem_q;
      kcs_pkg::SRC_Q:   dvd = quot;
      default:          dvd = t_q;
    endcase
  end

  kcs_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(dvd),
    .divisor_i(p_q), .done_o(done), .quot_o(quot), .rem_o(drem)
  );

  // Doubled digit plus incoming carry against p
  assign d2     = {drem, 1'b0} + {{kcs_pkg::PW{1'b0}}, carry_q};
  assign dig_cy = d2 >= {1'b0, p_q};

  // Operand and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q     <= '0;
      c_q     <= '0;
      rem_q   <= '0;
      vin_q   <= 1'b0;
      t_q     <= '0;
      nu_q    <= '0;
      car_q   <= '0;
      carry_q <= 1'b0;
      ov_q    <= 1'b0;
      orem_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        p_q     <= prime_i;
        c_q     <= c_i;
        rem_q   <= rem_i;
        vin_q   <= vin_i;
        t_q     <= c_i;
        nu_q    <= '0;
        car_q   <= '0;
        carry_q <= 1'b0;
      end
      if (cmd_i.take_q) t_q <= quot;
      if (cmd_i.nu_inc) nu_q <= nu_q + 1'b1;
      if (cmd_i.dig_step) begin
        if (dig_cy) begin
          car_q   <= car_q + 1'b1;
          carry_q <= 1'b1;
        end else begin
          carry_q <= 1'b0;
        end
      end
      if (cmd_i.set_out_pass) begin
        ov_q <= vin_q; orem_q <= rem_q;
      end
      if (cmd_i.set_out_kill) begin
        ov_q <= 1'b0; orem_q <= rem_q;
      end
      if (cmd_i.set_out_t) begin
        ov_q <= 1'b1; orem_q <= t_q;
      end
      if (cmd_i.set_out_q) begin
        ov_q <= 1'b1; orem_q <= quot;
      end
    end
  end

  // Status toward the controller; over counts the carry of the digit at hand
  always_comb begin
    sts_o.vin      = vin_q;
    sts_o.p_ok     = p_q >= kcs_pkg::PW'(2);
    sts_o.test_on  = {1'b0, p_q} > {{(kcs_pkg::PW-kcs_pkg::KW){1'b0}}, k_i, 1'b0};
    sts_o.c_small  = c_q < kcs_pkg::VW'(({1'b0, p_q} + 33'd1) >> 1);
    sts_o.c_lt_p   = c_q < kcs_pkg::VW'(p_q);
    sts_o.div_done = done;
    sts_o.rem_zero = drem == '0;
    sts_o.t_zero   = t_q == '0;
    sts_o.q_zero   = quot == '0;
    sts_o.over     = ({1'b0, car_q} + {{kcs_pkg::CW{1'b0}}, dig_cy}) > {1'b0, nu_q};
  end

  assign out_valid_o = ov_q;
  assign out_rem_o   = orem_q;
endmodule

// ===== rtl/core/kcs_ctrl.sv =====
// Controller: sequences the carry test and the stripping over the shared divider
module kcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kcs_pkg::cmd_t cmd_o,
  input  kcs_pkg::sts_t sts_i
);
  `include "kummer_carry_sieve_element_unit_assert.svh"

  kcs_pkg::state_e st_q, st_d;
  kcs_pkg::state_e ret_q, ret_d;
  logic            oval_q, oval_d;

  // Next state
  always_comb begin
    st_d   = st_q;
    ret_d  = ret_q;
    oval_d = oval_q;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    case (st_q)
      kcs_pkg::ST_IDLE: if (in_valid_i && !oval_q) st_d = kcs_pkg::ST_CHECK;
      kcs_pkg::ST_CHECK: begin
        if (!sts_i.vin || !sts_i.p_ok) st_d = kcs_pkg::ST_OUT;
        else if (!sts_i.test_on) begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_REM1;
        end else if (sts_i.c_small) st_d = kcs_pkg::ST_OUT;
        else if (sts_i.c_lt_p) begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_REM1;
        end else if (sts_i.t_zero) begin
          st_d = kcs_pkg::ST_OUT;
        end else begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_NU;
        end
      end
      kcs_pkg::ST_DIV: if (sts_i.div_done) st_d = ret_q;
      kcs_pkg::ST_NU: begin
        if (sts_i.rem_zero) st_d = kcs_pkg::ST_DIV;
        else begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_DIG;
        end
      end
      kcs_pkg::ST_DIG: begin
        if (sts_i.over) begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_REM1;
        end else if (sts_i.q_zero) st_d = kcs_pkg::ST_OUT;
        else st_d = kcs_pkg::ST_DIV;
      end
      kcs_pkg::ST_REM1: begin
        if (sts_i.q_zero) st_d = kcs_pkg::ST_OUT;
        else begin
          st_d = kcs_pkg::ST_DIV; ret_d = kcs_pkg::ST_STRIP;
        end
      end
      kcs_pkg::ST_STRIP: begin
        if (sts_i.rem_zero) st_d = kcs_pkg::ST_DIV;
        else st_d = kcs_pkg::ST_OUT;
      end
      kcs_pkg::ST_OUT: begin
        st_d   = kcs_pkg::ST_IDLE;
        oval_d = 1'b1;
      end
      default: st_d = kcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.div_src = kcs_pkg::SRC_T;
    in_ready_o = (st_q == kcs_pkg::ST_IDLE) && !oval_q;
    cmd_o.load = in_ready_o && in_valid_i;
    case (st_q)
      kcs_pkg::ST_CHECK: begin
        if (!sts_i.vin || !sts_i.p_ok || !sts_i.test_on) cmd_o.set_out_pass = 1'b1;
        if (!sts_i.vin || !sts_i.p_ok) begin
        end else if (!sts_i.test_on || (!sts_i.c_small && sts_i.c_lt_p)) begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = kcs_pkg::SRC_REM;
        end else if (sts_i.c_small || sts_i.t_zero) begin
          cmd_o.set_out_kill = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = kcs_pkg::SRC_C;
        end
      end
      // Factor p out of c, or redo the division of t for its lowest digit
      kcs_pkg::ST_NU: begin
        cmd_o.div_start = 1'b1;
        if (sts_i.rem_zero) begin
          cmd_o.take_q = 1'b1; cmd_o.nu_inc = 1'b1; cmd_o.div_src = kcs_pkg::SRC_Q;
        end
      end
      // One digit of the doubling: survive, fail on the last digit, or go on
      kcs_pkg::ST_DIG: begin
        cmd_o.dig_step = 1'b1;
        if (sts_i.over) begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = kcs_pkg::SRC_REM;
        end else if (sts_i.q_zero) begin
          cmd_o.set_out_kill = 1'b1;
        end else begin
          cmd_o.take_q    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = kcs_pkg::SRC_Q;
        end
      end
      kcs_pkg::ST_REM1: begin
        if (sts_i.q_zero) cmd_o.set_out_q = 1'b1;
        else begin
          cmd_o.take_q    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = kcs_pkg::SRC_Q;
        end
      end
      kcs_pkg::ST_STRIP: begin
        if (sts_i.rem_zero) begin
          cmd_o.take_q    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = kcs_pkg::SRC_Q;
        end else cmd_o.set_out_t = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= kcs_pkg::ST_IDLE;
      ret_q  <= kcs_pkg::ST_IDLE;
      oval_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      oval_q <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

  `KCS_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, st_q != kcs_pkg::ST_IDLE, !in_ready_o)
  `KCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, oval_q && !out_ready_i, oval_q)
  `KCS_ASSERT_NEXT(a_load_check, clk_i, rst_ni, cmd_o.load, st_q == kcs_pkg::ST_CHECK)
endmodule

// ===== rtl/core/kummer_carry_sieve_element_unit.sv =====
// Top level: Kummer carry sieve element unit
//   channel   dir  payload
//   in_ch     in   prime, multiple_index, remainder, in_valid
//   out_ch    out  out_valid, out_remainder
//   cfg       in   cfg_we_i / cfg_wdata_i (run_length_k)
// Each pass runs through the shared one-bit-per-cycle divider (ST_DIV) up to the next
// decision; a pass-through or early kill is decided in ST_CHECK and shown via ST_OUT.
// A full carry test and strip takes up to about 130 passes.
// One item is worked at a time; a waiting result holds in_ch.ready low until taken.
// Reset is asynchronous and active low; run_length_k resets to 1.
module kummer_carry_sieve_element_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [kcs_pkg::KW-1:0] cfg_wdata_i,
  kcs_in_if.sink                 in_ch,
  kcs_out_if.source              out_ch
);
  logic [kcs_pkg::KW-1:0] k_q;
  kcs_pkg::cmd_t          cmd;
  kcs_pkg::sts_t          sts;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_q <= kcs_pkg::KW'(1);
    else if (cfg_we_i) k_q <= cfg_wdata_i;
  end

  kcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .cmd_o(cmd), .sts_i(sts)
  );

  kcs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .k_i(k_q),
    .prime_i(in_ch.prime), .c_i(in_ch.multiple_index), .rem_i(in_ch.remainder),
    .vin_i(in_ch.in_valid), .out_valid_o(out_ch.out_valid),
    .out_rem_o(out_ch.out_remainder)
  );
endmodule

// ===== tb/kcs_sieve_checker.sv =====
// Checker: watches the channels, predicts each sieve element result and compares
`timescale 1ns / 1ps

module kcs_sieve_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [kcs_pkg::KW-1:0] cfg_wdata_i,
  kcs_in_if                      in_mon,
  kcs_out_if                     out_mon,
  output int                     errors_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     survivors_o
);
  typedef struct packed {
    logic                   keep;
    logic [kcs_pkg::VW-1:0] rem;
  } sieve_res_t;

  logic [kcs_pkg::KW-1:0] run_k;
  sieve_res_t             expected_results[$];

  // Kummer carry rule: true when doubling c in base p carries more than nu times
  function automatic logic carries_exceed(logic [63:0] p, logic [63:0] c);
    logic [63:0] t, nu, carries, d;
    logic        cy;
    t = c; nu = 0; carries = 0; cy = 0;
    if (c < ((p + 1) >> 1)) return 1'b0;
    if (c < p) return 1'b1;
    while (t > 0 && t % p == 0) begin
      nu++;
      t = t / p;
    end
    while (t > 0) begin
      d = t % p;
      if (d * 2 + cy >= p) begin
        carries++;
        cy = 1;
        if (carries > nu) break;
      end else begin
        cy = 0;
      end
      t = t / p;
    end
    return carries > nu;
  endfunction

  function automatic sieve_res_t predict_sieve_result(logic [kcs_pkg::PW-1:0] prime,
      logic [kcs_pkg::VW-1:0] c, logic [kcs_pkg::VW-1:0] rem, logic vin);
    sieve_res_t  r;
    logic [63:0] p, t;
    logic        ok;
    p = {32'b0, prime};
    r.keep = vin;
    r.rem  = rem;
    if (vin && p >= 2) begin
      ok = 1'b1;
      if (p > 2 * {48'b0, run_k}) ok = carries_exceed(p, c);
      if (!ok) begin
        r.keep = 1'b0;
      end else begin
        t = rem / p;
        if (t > 0)
          while (t % p == 0) t = t / p;
        r.rem = t;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_results.size();

  // Register copy, prediction on input transactions, compare on result transactions
  always @(posedge clk_i or negedge rst_ni) begin
    sieve_res_t want;
    if (!rst_ni) begin
      run_k       <= 1;
      errors_o    <= 0;
      results_o   <= 0;
      survivors_o <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) run_k <= cfg_wdata_i;
      if (in_mon.valid && in_mon.ready)
        expected_results = {expected_results, predict_sieve_result(in_mon.prime,
            in_mon.multiple_index, in_mon.remainder, in_mon.in_valid)};
      if (out_mon.valid && out_mon.ready) begin
        results_o <= results_o + 1;
        if (out_mon.out_valid) survivors_o <= survivors_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with none expected: valid %0b rem %0h",
                   $time, out_mon.out_valid, out_mon.out_remainder);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.keep !== out_mon.out_valid || want.rem !== out_mon.out_remainder) begin
            $display("%0t: mismatch: expected valid %0b rem %0h, got valid %0b rem %0h",
                     $time, want.keep, want.rem, out_mon.out_valid,
                     out_mon.out_remainder);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_kummer_carry_sieve_element_unit.sv =====
// Testbench top: stimulus, flow control, register settings and verdict
`timescale 1ns / 1ps

module tb_kummer_carry_sieve_element_unit;
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [kcs_pkg::KW-1:0] cfg_wdata_i = '0;
  int                     errors, pending, results, survivors;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     sent = 0;

  kcs_in_if  in_ch();
  kcs_out_if out_ch();

  kummer_carry_sieve_element_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  kcs_sieve_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_mon(in_ch), .out_mon(out_ch), .errors_o(errors), .pending_o(pending),
    .results_o(results), .survivors_o(survivors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.prime = '0;
    in_ch.multiple_index = '0;
    in_ch.remainder = '0;
    in_ch.in_valid = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Result-side back-pressure
  always @(posedge clk_i)
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic send_element(logic [kcs_pkg::PW-1:0] p, logic [kcs_pkg::VW-1:0] c,
                              logic [kcs_pkg::VW-1:0] rem, logic vin);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.prime          <= p;
    in_ch.multiple_index <= c;
    in_ch.remainder      <= rem;
    in_ch.in_valid       <= vin;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  // Register write once the last transaction has been predicted and taken
  task automatic write_run_k(logic [kcs_pkg::KW-1:0] k);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random elements: primes 2, 3, 65521 and 2^32-5 mixed with odd, random and degenerate p; c near the carry boundaries
  task automatic send_random_element();
    logic [kcs_pkg::PW-1:0] p;
    logic [kcs_pkg::VW-1:0] c, rem;
    int                     sel, j;
    sel = $urandom_range(0, 99);
    if (sel < 5)       p = 2;
    else if (sel < 12) p = 3;
    else if (sel < 30) p = kcs_pkg::PW'({$urandom_range(0, 15), 1'b1});
    else if (sel < 45) p = $urandom_range(17, 2000);
    else if (sel < 55) p = 65521;
    else if (sel < 65) p = 32'hFFFF_FFFB;
    else if (sel < 70) p = $urandom_range(0, 1);
    else               p = $urandom();
    sel = $urandom_range(0, 99);
    if (p < 4 && sel < 90) c = $urandom_range(0, 4095);
    else if (sel < 25)     c = $urandom_range(0, p);
    else if (sel < 55)     c = p * $urandom_range(1, 64) + $urandom_range(0, p);
    else if (sel < 70)     c = p * p * $urandom_range(1, 40);
    else                   c = rand64();
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      rem = 0;
    end else if (sel < 60) begin
      rem = $urandom_range(1, 1000);
      j = $urandom_range(0, 4);
      repeat (j) if (rem * p / p == rem) rem = rem * p;
    end else begin
      rem = rand64();
    end
    send_element(p, c, rem, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    logic [kcs_pkg::KW-1:0] k_list[5];
    int                     idle_send[4], idle_recv[4];
    k_list = '{16'd1, 16'd65535, 16'd7, 16'd1000, 16'd300};
    idle_send = '{0, 47, 0, 37};
    idle_recv = '{0, 0, 47, 37};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, cleared flag, prime below two, zero remainder, prime two
    send_element(13, 20, 13 * 13 * 5, 1'b1);
    send_element(13, 20, 13 * 13 * 5, 1'b0);
    send_element(0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_element(1, 5, 77, 1'b1);
    send_element(1, 5, 77, 1'b0);
    send_element(7, 3, 49, 1'b1);
    send_element(7, 4, 49, 1'b1);
    send_element(7, 6, 0, 1'b1);
    send_element(7, 49, 98, 1'b1);
    send_element(7, 7 * 4, 7 * 7 * 7, 1'b1);
    send_element(7, 7 * 7 * 7 * 6, 7, 1'b1);
    send_element(2, 1, 64'h8000_0000_0000_0000, 1'b1);
    send_element(2, 3, 12, 1'b1);
    send_element(2, 0, 5, 1'b1);
    send_element(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_element(32'hFFFF_FFFB, 64'h7FFF_FFFD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_element(32'hFFFF_FFFB, 0, 0, 1'b1);
    send_element(3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555, 1'b1);
    send_element(5, 64'hAAAA_AAAA_AAAA_AAAA, 25, 1'b1);
    write_run_k(16'd65535);
    send_element(65521, 20, 65521 * 3, 1'b1);
    send_element(32'hFFFF_FFFB, 3, 10, 1'b1);
    send_element(131071, 2, 131071, 1'b1);

    // Random phases: each idle mode under several register settings
    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 5; s++) begin
        write_run_k(k_list[(ph + s) % 5]);
        send_idle_pct  = idle_send[ph];
        recv_stall_pct = idle_recv[ph];
        repeat (58) send_random_element();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d sieve elements (%0d results, %0d survivors) over four flow-control",
             sent, results, survivors);
    $display("modes and run lengths 1 to 65535.");
    if (errors == 0)
      $display("tb_kummer_carry_sieve_element_unit passed");
    else
      $display("tb_kummer_carry_sieve_element_unit failed");
    $finish;
  end

  // Run-time limit
  initial begin
    #400_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("tb_kummer_carry_sieve_element_unit failed");
    $finish;
  end
endmodule
